// ===== hdl/jsph_pkg.sv =====
// Shared types, constants and helpers for the joint symbol pattern histogram.
package jsph_pkg;

   localparam int unsigned MAX_ALPHABET  = 20;
   localparam int unsigned COUNT_BITS    = 32;
   localparam int unsigned FRACTION_BITS = 16;

   localparam int unsigned NUC_ALPHA   = (4 > MAX_ALPHABET) ? MAX_ALPHABET : 4;
   localparam int unsigned AMINO_ALPHA = (20 > MAX_ALPHABET) ? MAX_ALPHABET : 20;
   localparam int unsigned NUC_LIMIT   = NUC_ALPHA * NUC_ALPHA * NUC_ALPHA * NUC_ALPHA;
   localparam int unsigned AMINO_LIMIT = AMINO_ALPHA * AMINO_ALPHA * AMINO_ALPHA * AMINO_ALPHA;
   localparam int unsigned STORE_DEPTH =
      MAX_ALPHABET * MAX_ALPHABET * MAX_ALPHABET * MAX_ALPHABET;

   localparam int unsigned ADDR_BITS  = $clog2(STORE_DEPTH);
   localparam int unsigned SYM_BITS   = $clog2(MAX_ALPHABET);
   localparam int unsigned ALPHA_BITS = $clog2(MAX_ALPHABET + 1);
   localparam int unsigned QUOT_BITS  = FRACTION_BITS + 1;
   localparam int unsigned STEP_BITS  = $clog2(FRACTION_BITS + 2);

   localparam logic [1:0] ACT_COUNT = 2'd0;
   localparam logic [1:0] ACT_READ  = 2'd1;
   localparam logic [1:0] ACT_CLEAR = 2'd2;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK,
      ST_UPDATE,
      ST_DIVIDE,
      ST_SEND
   } state_type;

   typedef struct packed {
      logic [1:0]  action;
      logic [7:0]  sym_a;
      logic [7:0]  sym_b;
      logic [7:0]  sym_c;
      logic [7:0]  sym_d;
      logic [17:0] bin_index;
   } req_type;

   typedef struct packed {
      logic [16:0] frequency;
      logic [31:0] bin_count;
      logic [31:0] site_total;
      logic        site_kept;
      logic        no_sites;
      logic        index_out_of_range;
   } rsp_type;

   function automatic logic [31:0] clamp32(logic [COUNT_BITS-1:0] value);
      logic [63:0] wide;
      wide = 64'(value);
      return (wide > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
   endfunction

endpackage

// ===== hdl/jsph_divider.sv =====
// Bit-serial rounding divider producing count / sites in unsigned fixed point.
module jsph_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [jsph_pkg::COUNT_BITS-1:0]      dividend,
   input  logic [jsph_pkg::COUNT_BITS-1:0]      divisor,
   output logic                                 done,
   output logic [jsph_pkg::QUOT_BITS-1:0]       quotient
);

   localparam logic [jsph_pkg::STEP_BITS-1:0] LAST_STEP =
      jsph_pkg::STEP_BITS'(jsph_pkg::FRACTION_BITS + 1);

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [jsph_pkg::STEP_BITS-1:0]      step_ff, step_in;
   logic [jsph_pkg::COUNT_BITS:0]       rem_ff, rem_in;
   logic [jsph_pkg::COUNT_BITS-1:0]     div_ff, div_in;
   logic [jsph_pkg::QUOT_BITS-1:0]      quo_ff, quo_in;
   logic                                ge;
   logic [jsph_pkg::COUNT_BITS:0]       diff;

   always_comb begin
      ge      = rem_ff >= {1'b0, div_ff};
      diff    = ge ? (rem_ff - {1'b0, div_ff}) : rem_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = {1'b0, dividend};
         div_in  = divisor;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (step_ff == LAST_STEP) begin
            // final step rounds half up
            quo_in  = quo_ff + jsph_pkg::QUOT_BITS'(ge);
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            rem_in  = {diff[jsph_pkg::COUNT_BITS-1:0], 1'b0};
            quo_in  = {quo_ff[jsph_pkg::QUOT_BITS-2:0], ge};
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      step_ff <= step_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== hdl/joint_symbol_pattern_histogram.sv =====
// Top level: joint histogram of four-symbol alignment columns in one bin memory.
//
// After reset the block sweeps the bin memory to zero, one entry per cycle
// (STORE_DEPTH = 160000 entries), with req_ready low; csr writes are taken
// throughout. A count or a skipped column passes from transfer to result
// through payload capture, address formation with the memory read, the
// read-modify-write of the bin, and the output load. The single bin memory
// (registered read, then write-back) sets these steps. A read takes the same
// steps, plus a pass through the bit-serial divider when there are kept
// sites and the bin is in range. A clear runs the same sweep before its
// result. The next request is taken while a result still waits on
// rsp_ready.
module joint_symbol_pattern_histogram (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_enable,
   input  logic              csr_write_data,
   input  logic              req_valid,
   output logic              req_ready,
   input  jsph_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output jsph_pkg::rsp_type rsp_payload
);

   localparam logic [jsph_pkg::ADDR_BITS-1:0] LAST_ADDR =
      jsph_pkg::ADDR_BITS'(jsph_pkg::STORE_DEPTH - 1);

   function automatic logic [jsph_pkg::ADDR_BITS-1:0] radix_step(
      logic [jsph_pkg::ADDR_BITS-1:0] acc,
      logic [7:0]                     sym,
      logic                           prot
   );
      logic [jsph_pkg::ADDR_BITS-1:0] s;
      s = jsph_pkg::ADDR_BITS'(jsph_pkg::SYM_BITS'(sym));
      return prot ? jsph_pkg::ADDR_BITS'(acc * jsph_pkg::ADDR_BITS'(jsph_pkg::AMINO_ALPHA) + s)
                  : jsph_pkg::ADDR_BITS'(acc * jsph_pkg::ADDR_BITS'(jsph_pkg::NUC_ALPHA) + s);
   endfunction

   function automatic logic [jsph_pkg::COUNT_BITS-1:0] sat_inc(
      logic [jsph_pkg::COUNT_BITS-1:0] value
   );
      return (&value) ? value : value + 1'b1;
   endfunction

   logic [jsph_pkg::COUNT_BITS-1:0] bin_mem [jsph_pkg::STORE_DEPTH];

   jsph_pkg::state_type              state_ff, state_in;
   logic                             protein_ff;
   jsph_pkg::req_type                req_ff, req_in;
   logic [jsph_pkg::ADDR_BITS-1:0]   addr_ff, addr_in;
   logic                             kept_ff, kept_in;
   logic [jsph_pkg::COUNT_BITS-1:0]  rd_ff;
   logic [jsph_pkg::COUNT_BITS-1:0]  site_ff, site_in;
   logic [jsph_pkg::ADDR_BITS-1:0]   sweep_ff, sweep_in;
   logic                             reply_ff, reply_in;
   jsph_pkg::rsp_type                res_ff, res_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   jsph_pkg::rsp_type                rsp_ff, rsp_in;

   logic                             mem_we;
   logic [jsph_pkg::ADDR_BITS-1:0]   mem_wa, mem_ra;
   logic [jsph_pkg::COUNT_BITS-1:0]  mem_wd;

   logic [jsph_pkg::ALPHA_BITS-1:0]  alpha;
   logic [31:0]                      limit;
   logic                             syms_ok;
   logic [jsph_pkg::ADDR_BITS-1:0]   pattern_idx;
   logic [jsph_pkg::COUNT_BITS-1:0]  bin_new;
   logic                             no_sites, out_of_range;

   logic                             div_start, div_done;
   logic [jsph_pkg::COUNT_BITS-1:0]  div_dividend;
   logic [jsph_pkg::QUOT_BITS-1:0]   div_quot;

   assign alpha = protein_ff ? jsph_pkg::ALPHA_BITS'(jsph_pkg::AMINO_ALPHA)
                             : jsph_pkg::ALPHA_BITS'(jsph_pkg::NUC_ALPHA);
   assign limit = protein_ff ? 32'(jsph_pkg::AMINO_LIMIT) : 32'(jsph_pkg::NUC_LIMIT);

   assign syms_ok = (req_ff.sym_a < 8'(alpha)) && (req_ff.sym_b < 8'(alpha)) &&
                    (req_ff.sym_c < 8'(alpha)) && (req_ff.sym_d < 8'(alpha));
   assign pattern_idx = radix_step(radix_step(radix_step(
                           jsph_pkg::ADDR_BITS'(jsph_pkg::SYM_BITS'(req_ff.sym_a)),
                           req_ff.sym_b, protein_ff), req_ff.sym_c, protein_ff),
                           req_ff.sym_d, protein_ff);

   assign bin_new      = sat_inc(rd_ff);
   assign no_sites     = (site_ff == '0);
   assign out_of_range = (32'(req_ff.bin_index) >= limit);
   assign div_dividend = (rd_ff > site_ff) ? site_ff : rd_ff;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      addr_in      = addr_ff;
      kept_in      = kept_ff;
      site_in      = site_ff;
      sweep_in     = sweep_ff;
      reply_in     = reply_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      req_ready    = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = addr_ff;
      mem_wd       = bin_new;
      mem_ra       = addr_ff;
      div_start    = 1'b0;

      unique case (state_ff)
         jsph_pkg::ST_CLEAR: begin
            mem_we   = 1'b1;
            mem_wa   = sweep_ff;
            mem_wd   = '0;
            sweep_in = sweep_ff + 1'b1;
            if (sweep_ff == LAST_ADDR) begin
               sweep_in = '0;
               reply_in = 1'b0;
               state_in = reply_ff ? jsph_pkg::ST_SEND : jsph_pkg::ST_IDLE;
            end
         end
         jsph_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in   = req_payload;
               state_in = jsph_pkg::ST_LOOK;
            end
         end
         jsph_pkg::ST_LOOK: begin
            addr_in  = (req_ff.action == jsph_pkg::ACT_READ)
                       ? jsph_pkg::ADDR_BITS'(req_ff.bin_index) : pattern_idx;
            kept_in  = (req_ff.action == jsph_pkg::ACT_COUNT) && syms_ok;
            mem_ra   = addr_in;
            state_in = jsph_pkg::ST_UPDATE;
         end
         jsph_pkg::ST_UPDATE: begin
            res_in            = '0;
            res_in.site_total = jsph_pkg::clamp32(site_ff);
            state_in          = jsph_pkg::ST_SEND;
            unique case (req_ff.action)
               jsph_pkg::ACT_COUNT: begin
                  if (kept_ff) begin
                     mem_we            = 1'b1;
                     site_in           = sat_inc(site_ff);
                     res_in.bin_count  = jsph_pkg::clamp32(bin_new);
                     res_in.site_total = jsph_pkg::clamp32(sat_inc(site_ff));
                     res_in.site_kept  = 1'b1;
                  end
               end
               jsph_pkg::ACT_READ: begin
                  res_in.no_sites           = no_sites;
                  res_in.index_out_of_range = out_of_range;
                  if (!out_of_range) begin
                     res_in.bin_count = jsph_pkg::clamp32(rd_ff);
                     if (!no_sites) begin
                        div_start = 1'b1;
                        state_in  = jsph_pkg::ST_DIVIDE;
                     end
                  end
               end
               jsph_pkg::ACT_CLEAR: begin
                  site_in           = '0;
                  res_in.site_total = '0;
                  reply_in          = 1'b1;
                  sweep_in          = '0;
                  state_in          = jsph_pkg::ST_CLEAR;
               end
               default: begin
                  state_in = jsph_pkg::ST_SEND;
               end
            endcase
         end
         jsph_pkg::ST_DIVIDE: begin
            if (div_done) begin
               res_in.frequency = 17'(div_quot);
               state_in         = jsph_pkg::ST_SEND;
            end
         end
         jsph_pkg::ST_SEND: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = jsph_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = jsph_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         bin_mem[mem_wa] <= mem_wd;
      end
      rd_ff <= bin_mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jsph_pkg::ST_CLEAR;
         protein_ff   <= 1'b0;
         site_ff      <= '0;
         sweep_ff     <= '0;
         reply_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         site_ff      <= site_in;
         sweep_ff     <= sweep_in;
         reply_ff     <= reply_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            protein_ff <= csr_write_data;
         end
      end
      req_ff  <= req_in;
      addr_ff <= addr_in;
      kept_ff <= kept_in;
      res_ff  <= res_in;
      rsp_ff  <= rsp_in;
   end

   jsph_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (site_ff),
      .done     (div_done),
      .quotient (div_quot)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// ===== bench/joint_symbol_pattern_histogram_tb.sv =====
// Self-checking bench for the joint symbol pattern histogram: directed and random traffic against a mirror.
module joint_symbol_pattern_histogram_tb;

   localparam logic [1:0] ACT_NOP = 2'd3;

   class histogram_mirror;
      bit [jsph_pkg::COUNT_BITS-1:0] bin_tally [jsph_pkg::STORE_DEPTH];
      bit [jsph_pkg::COUNT_BITS-1:0] kept_sites;
      bit                            protein;
      jsph_pkg::rsp_type             awaited [$];
      int                            faults;

      function bit [31:0] clip32(bit [63:0] v);
         return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
      endfunction

      function void apply_request(jsph_pkg::req_type item);
         jsph_pkg::rsp_type want;
         int unsigned       alpha, idx, span;
         bit [63:0]         part, sites, whole;
         want = '0;
         alpha = protein ? jsph_pkg::AMINO_ALPHA : jsph_pkg::NUC_ALPHA;
         span = alpha * alpha * alpha * alpha;
         sites = 64'(kept_sites);
         case (item.action)
            jsph_pkg::ACT_COUNT: begin
               if (32'(item.sym_a) < alpha && 32'(item.sym_b) < alpha &&
                   32'(item.sym_c) < alpha && 32'(item.sym_d) < alpha) begin
                  idx = ((32'(item.sym_a) * alpha + 32'(item.sym_b)) * alpha +
                         32'(item.sym_c)) * alpha + 32'(item.sym_d);
                  if (bin_tally[idx] != '1) bin_tally[idx]++;
                  want.bin_count = clip32(64'(bin_tally[idx]));
                  if (kept_sites != '1) kept_sites++;
                  want.site_kept = 1'b1;
               end
            end
            jsph_pkg::ACT_READ: begin
               want.no_sites = (kept_sites == '0);
               if (32'(item.bin_index) >= span) begin
                  want.index_out_of_range = 1'b1;
               end else begin
                  part = 64'(bin_tally[32'(item.bin_index)]);
                  want.bin_count = clip32(part);
                  if (kept_sites != '0) begin
                     if (part > sites) part = sites;
                     // round half up of count * 2^F / sites
                     whole = ((part << (jsph_pkg::FRACTION_BITS + 1)) + sites) / (sites << 1);
                     want.frequency = whole[16:0];
                  end
               end
            end
            jsph_pkg::ACT_CLEAR: begin
               for (int unsigned i = 0; i < jsph_pkg::STORE_DEPTH; i++) bin_tally[i] = '0;
               kept_sites = '0;
            end
            default: ;
         endcase
         want.site_total = clip32(64'(kept_sites));
         awaited.insert(awaited.size(), want);
      endfunction

      function void compare_field(string name, bit [31:0] want, bit [31:0] got);
         if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
         end
      endfunction

      function void match_reply(jsph_pkg::rsp_type got);
         jsph_pkg::rsp_type want;
         if (awaited.size() == 0) begin
            $error("result transfer with nothing outstanding");
            faults++;
            return;
         end
         want = awaited.pop_front();
         compare_field("frequency", 32'(want.frequency), 32'(got.frequency));
         compare_field("bin_count", want.bin_count, got.bin_count);
         compare_field("site_total", want.site_total, got.site_total);
         compare_field("site_kept", 32'(want.site_kept), 32'(got.site_kept));
         compare_field("no_sites", 32'(want.no_sites), 32'(got.no_sites));
         compare_field("index_out_of_range", 32'(want.index_out_of_range),
                       32'(got.index_out_of_range));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              csr_write_enable = 1'b0;
   logic              csr_write_data = 1'b0;
   logic              req_valid = 1'b0;
   logic              req_ready;
   jsph_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   jsph_pkg::rsp_type rsp_payload;

   histogram_mirror sb = new();
   bit              steady_run;
   bit              protein_sel;
   int unsigned     recent_bins [$];

   joint_symbol_pattern_histogram u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_payload     (req_payload),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_payload     (rsp_payload)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) sb.apply_request(req_payload);
         if (rsp_valid && rsp_ready) sb.match_reply(rsp_payload);
      end
   end

   function automatic int pick_gap();
      int roll;
      roll = int'($urandom_range(0, 99));
      if (steady_run || roll < 60) return 0;
      if (roll < 94) return int'($urandom_range(1, 3));
      return int'($urandom_range(8, 40));
   endfunction

   function automatic jsph_pkg::req_type make_req(input logic [1:0] act,
                                                  input int unsigned a, b, c, d, bin);
      jsph_pkg::req_type item;
      item.action = act;
      item.sym_a = 8'(a);
      item.sym_b = 8'(b);
      item.sym_c = 8'(c);
      item.sym_d = 8'(d);
      item.bin_index = 18'(bin);
      return item;
   endfunction

   function automatic jsph_pkg::req_type draw_request();
      jsph_pkg::req_type item;
      int unsigned       alpha, roll, top, pick, idx;
      alpha = protein_sel ? jsph_pkg::AMINO_ALPHA : jsph_pkg::NUC_ALPHA;
      item = make_req(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom, $urandom,
                      $urandom);
      roll = $urandom_range(0, 99);
      if (roll < 74) begin
         item.action = jsph_pkg::ACT_COUNT;
         top = ($urandom_range(0, 1) == 0) ? 2 : alpha - 1;
         item.sym_a = 8'($urandom_range(0, top));
         item.sym_b = 8'($urandom_range(0, top));
         item.sym_c = 8'($urandom_range(0, top));
         item.sym_d = 8'($urandom_range(0, top));
         if ($urandom_range(0, 9) == 0) begin
            case ($urandom_range(0, 3))
               0: item.sym_a = 8'($urandom_range(alpha, 255));
               1: item.sym_b = 8'($urandom_range(alpha, 255));
               2: item.sym_c = 8'($urandom_range(alpha, 255));
               default: item.sym_d = 8'($urandom_range(alpha, 255));
            endcase
         end else begin
            idx = ((32'(item.sym_a) * alpha + 32'(item.sym_b)) * alpha +
                   32'(item.sym_c)) * alpha + 32'(item.sym_d);
            recent_bins.insert(recent_bins.size(), idx);
            if (recent_bins.size() > 32) void'(recent_bins.pop_front());
         end
      end else if (roll < 96) begin
         item.action = jsph_pkg::ACT_READ;
         pick = $urandom_range(0, 9);
         if (pick < 6 && recent_bins.size() > 0)
            item.bin_index = 18'(recent_bins[$urandom_range(0, recent_bins.size() - 1)]);
         else if (pick < 8)
            item.bin_index = 18'($urandom_range(0, alpha * alpha * alpha * alpha - 1));
      end else if (roll < 98) begin
         item.action = ACT_NOP;
      end else begin
         item.action = jsph_pkg::ACT_COUNT;
      end
      return item;
   endfunction

   task automatic send_req(input jsph_pkg::req_type item);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.awaited.size() != 0);
   endtask

   task automatic write_mode(input bit value);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.protein = value;
      protein_sel = value;
   endtask

   initial begin
      int stall, hold;
      forever begin
         stall = pick_gap();
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         hold = int'($urandom_range(1, 12));
         repeat (hold) @(posedge clock);
      end
   end

   initial begin
      #60_000_000;
      $display("FAIL joint_symbol_pattern_histogram");
      $finish;
   end

   initial begin
      int unsigned phase, n;
      int          clear_at;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_mode(1'b0);

      // nucleotide alphabet: empty store, full and partial frequencies, skips
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 0));
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 256));
      send_req(make_req(jsph_pkg::ACT_COUNT, 0, 0, 0, 0, 0));
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 0));
      send_req(make_req(jsph_pkg::ACT_COUNT, 3, 3, 3, 3, 0));
      send_req(make_req(jsph_pkg::ACT_COUNT, 4, 0, 0, 0, 0));
      send_req(make_req(jsph_pkg::ACT_COUNT, 0, 0, 0, 255, 0));
      send_req(make_req(jsph_pkg::ACT_COUNT, 255, 255, 255, 255, 262143));
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 255));
      send_req(make_req(jsph_pkg::ACT_READ, 255, 255, 255, 255, 1));
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 262143));
      send_req(make_req(ACT_NOP, 1, 2, 3, 0, 255));
      send_req(make_req(jsph_pkg::ACT_COUNT, 1, 2, 3, 0, 0));
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 255));
      send_req(make_req(jsph_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 255));
      wait_drained();

      // amino acid alphabet: top symbol, first bad symbol, store edge
      write_mode(1'b1);
      send_req(make_req(jsph_pkg::ACT_COUNT, 19, 19, 19, 19, 0));
      send_req(make_req(jsph_pkg::ACT_COUNT, 20, 0, 0, 0, 0));
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 159999));
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 160000));
      send_req(make_req(jsph_pkg::ACT_READ, 0, 0, 0, 0, 255));

      for (phase = 0; phase < 6; phase++) begin
         wait_drained();
         write_mode(phase[0]);
         recent_bins.delete();
         clear_at = (phase == 3) ? int'($urandom_range(20, 190)) : -1;
         for (n = 0; n < 215; n++) begin
            if (n % 64 == 0) steady_run = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 199) == 0) wait_drained();
            if (int'(n) == clear_at) send_req(make_req(jsph_pkg::ACT_CLEAR, 0, 0, 0, 0, 0));
            else send_req(draw_request());
         end
      end

      wait_drained();
      repeat (30) @(posedge clock);
      if (sb.faults == 0) begin
         $display("PASS joint_symbol_pattern_histogram");
      end else begin
         $display("FAIL joint_symbol_pattern_histogram");
      end
      $finish;
   end

endmodule
